// File: hdl/tbpr_pkg.sv
// Package for the tape block pause rewriter: block IDs, per-ID header rules,
// the parser phase type and the result record passed to the top level.
// No dependencies.
package tbpr_pkg;

    // Signature length in bytes
    localparam int unsigned SIG_LEN = 10;

    // Default width of the sound block counter
    localparam int unsigned COUNT_BITS_DEF = 16;

    // Configuration register indexes
    localparam logic REG_PAUSE_MS = 1'b0;

    // Block IDs
    localparam logic [7:0] ID_STD         = 8'h10;
    localparam logic [7:0] ID_TURBO       = 8'h11;
    localparam logic [7:0] ID_TONE        = 8'h12;
    localparam logic [7:0] ID_PULSES      = 8'h13;
    localparam logic [7:0] ID_PURE_DATA   = 8'h14;
    localparam logic [7:0] ID_DIRECT      = 8'h15;
    localparam logic [7:0] ID_PAUSE       = 8'h20;
    localparam logic [7:0] ID_GROUP_START = 8'h21;
    localparam logic [7:0] ID_GROUP_END   = 8'h22;
    localparam logic [7:0] ID_JUMP        = 8'h23;
    localparam logic [7:0] ID_TEXT        = 8'h30;
    localparam logic [7:0] ID_MESSAGE     = 8'h31;
    localparam logic [7:0] ID_ARCHIVE     = 8'h32;
    localparam logic [7:0] ID_HW_TYPE     = 8'h33;
    localparam logic [7:0] ID_EMU_INFO    = 8'h34;
    localparam logic [7:0] ID_CUSTOM      = 8'h35;
    localparam logic [7:0] ID_SNAPSHOT    = 8'h40;
    localparam logic [7:0] ID_GLUE        = 8'h5A;

    // Length multiplier codes
    localparam logic [1:0] MULT_X1 = 2'd1;
    localparam logic [1:0] MULT_X2 = 2'd2;
    localparam logic [1:0] MULT_X3 = 2'd3;

    typedef enum logic [1:0] {
        PH_SIG,
        PH_ID,
        PH_HDR,
        PH_PAY
    } phase_t;

    typedef struct packed {
        logic [4:0] hdr;
        logic       has_pause;
        logic [4:0] pause_off;
        logic [4:0] len_off;
        logic [2:0] len_w;
        logic [1:0] mult;
        logic       known;
    } rule_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        pause_replaced;
        logic        block_start;
        logic [15:0] sound_block_count;
        logic        saw_direct;
        logic        saw_unknown;
    } result_t;

    // Header rule for one block ID; unknown IDs get the extension rule
    function automatic rule_t block_rule(input logic [7:0] id);
        rule_t r;
        r = '{hdr: 5'd0, has_pause: 1'b0, pause_off: 5'd0, len_off: 5'd0,
              len_w: 3'd0, mult: MULT_X1, known: 1'b1};
        case (id)
            ID_STD:
            begin
                r.hdr = 5'd4; r.has_pause = 1'b1; r.pause_off = 5'd0;
                r.len_off = 5'd2; r.len_w = 3'd2;
            end
            ID_TURBO:
            begin
                r.hdr = 5'd18; r.has_pause = 1'b1; r.pause_off = 5'd13;
                r.len_off = 5'd15; r.len_w = 3'd3;
            end
            ID_TONE:        r.hdr = 5'd4;
            ID_PULSES:
            begin
                r.hdr = 5'd1; r.len_w = 3'd1; r.mult = MULT_X2;
            end
            ID_PURE_DATA:
            begin
                r.hdr = 5'd10; r.has_pause = 1'b1; r.pause_off = 5'd5;
                r.len_off = 5'd7; r.len_w = 3'd3;
            end
            ID_DIRECT:
            begin
                r.hdr = 5'd8; r.has_pause = 1'b1; r.pause_off = 5'd2;
                r.len_off = 5'd5; r.len_w = 3'd3;
            end
            ID_PAUSE:
            begin
                r.hdr = 5'd2; r.has_pause = 1'b1; r.pause_off = 5'd0;
            end
            ID_GROUP_START:
            begin
                r.hdr = 5'd1; r.len_w = 3'd1;
            end
            ID_GROUP_END:   r.hdr = 5'd0;
            ID_JUMP:        r.hdr = 5'd2;
            ID_TEXT:
            begin
                r.hdr = 5'd1; r.len_w = 3'd1;
            end
            ID_MESSAGE:
            begin
                r.hdr = 5'd2; r.len_off = 5'd1; r.len_w = 3'd1;
            end
            ID_ARCHIVE:
            begin
                r.hdr = 5'd2; r.len_w = 3'd2;
            end
            ID_HW_TYPE:
            begin
                r.hdr = 5'd1; r.len_w = 3'd1; r.mult = MULT_X3;
            end
            ID_EMU_INFO:    r.hdr = 5'd8;
            ID_CUSTOM:
            begin
                r.hdr = 5'd20; r.len_off = 5'd16; r.len_w = 3'd4;
            end
            ID_SNAPSHOT:
            begin
                r.hdr = 5'd11; r.len_off = 5'd8; r.len_w = 3'd3;
            end
            ID_GLUE:        r.hdr = 5'd9;
            default:
            begin
                r.hdr = 5'd4; r.len_w = 3'd4; r.known = 1'b0;
            end
        endcase
        return r;
    endfunction

endpackage

// File: hdl/tbpr_parser.sv
// Block parser: phase state machine, header walk, payload counter, sound
// block counter and sticky flags. Produces the result for the byte in flight.
// Depends on tbpr_pkg.
module tbpr_parser
    import tbpr_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    input  logic [15:0] pause_ms,
    output result_t     res
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;
    localparam logic [3:0]            SIG_END = 4'(SIG_LEN);

    phase_t                phase_reg, phase_next;
    logic [3:0]            sig_count_reg, sig_count_next;
    logic [7:0]            current_id_reg, current_id_next;
    logic [4:0]            header_offset_reg, header_offset_next;
    logic [31:0]           length_acc_reg, length_acc_next;
    logic [31:0]           payload_left_reg, payload_left_next;
    logic [COUNT_BITS-1:0] block_counter_reg, block_counter_next;
    logic                  direct_flag_reg, direct_flag_next;
    logic                  unknown_flag_reg, unknown_flag_next;

    // State after an optional start-of-file clear
    phase_t                cur_phase;
    logic [3:0]            cur_sig;
    logic [7:0]            cur_id;
    logic [4:0]            cur_hoff;
    logic [31:0]           cur_acc;
    logic [31:0]           cur_pay;
    logic [COUNT_BITS-1:0] cur_cnt;
    logic                  cur_direct;
    logic                  cur_unknown;

    rule_t                 rule;
    logic [3:0]            sig_inc;
    logic [4:0]            hoff_inc;
    logic [4:0]            lane;
    logic [31:0]           acc_hdr;
    logic [31:0]           pay_dec;
    logic [31:0]           pay_load;
    logic                  in_len;
    logic [COUNT_BITS+15:0] cnt_ext;
    logic [7:0]            ob;
    logic                  repl;
    logic                  bstart;

    // Payload length from the header length field
    function automatic logic [31:0] scale_len(input logic [31:0] acc,
                                              input logic [1:0] mult);
        logic [31:0] s;
        case (mult)
            MULT_X2: s = {acc[30:0], 1'b0};
            MULT_X3: s = acc + {acc[30:0], 1'b0};
            default: s = acc;
        endcase
        return s;
    endfunction

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_SIG;
            sig_count_reg     <= '0;
            current_id_reg    <= '0;
            header_offset_reg <= '0;
            length_acc_reg    <= '0;
            payload_left_reg  <= '0;
            block_counter_reg <= '0;
            direct_flag_reg   <= 1'b0;
            unknown_flag_reg  <= 1'b0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            sig_count_reg     <= sig_count_next;
            current_id_reg    <= current_id_next;
            header_offset_reg <= header_offset_next;
            length_acc_reg    <= length_acc_next;
            payload_left_reg  <= payload_left_next;
            block_counter_reg <= block_counter_next;
            direct_flag_reg   <= direct_flag_next;
            unknown_flag_reg  <= unknown_flag_next;
        end
    end

    // Start of file clears the parser before the byte is taken
    always_comb
    begin
        if (start_of_file)
        begin
            cur_phase   = PH_SIG;
            cur_sig     = '0;
            cur_id      = '0;
            cur_hoff    = '0;
            cur_acc     = '0;
            cur_pay     = '0;
            cur_cnt     = '0;
            cur_direct  = 1'b0;
            cur_unknown = 1'b0;
        end
        else
        begin
            cur_phase   = phase_reg;
            cur_sig     = sig_count_reg;
            cur_id      = current_id_reg;
            cur_hoff    = header_offset_reg;
            cur_acc     = length_acc_reg;
            cur_pay     = payload_left_reg;
            cur_cnt     = block_counter_reg;
            cur_direct  = direct_flag_reg;
            cur_unknown = unknown_flag_reg;
        end
    end

    // Rule lookup, header field arithmetic
    always_comb
    begin
        rule     = block_rule((cur_phase == PH_ID) ? data_byte : cur_id);
        sig_inc  = cur_sig + 4'd1;
        hoff_inc = cur_hoff + 5'd1;
        lane     = cur_hoff - rule.len_off;
        in_len   = (rule.len_w != 3'd0) && (cur_hoff >= rule.len_off) &&
                   ({1'b0, cur_hoff} < ({1'b0, rule.len_off} + {3'b000, rule.len_w}));
        acc_hdr  = in_len ? (cur_acc | ({24'd0, data_byte} << {lane[1:0], 3'b000}))
                          : cur_acc;
        pay_dec  = cur_pay - 32'd1;
        pay_load = scale_len((cur_phase == PH_ID) ? 32'd0 : acc_hdr, rule.mult);
    end

    // Next state and result
    always_comb
    begin
        phase_next         = cur_phase;
        sig_count_next     = cur_sig;
        current_id_next    = cur_id;
        header_offset_next = cur_hoff;
        length_acc_next    = cur_acc;
        payload_left_next  = cur_pay;
        block_counter_next = cur_cnt;
        direct_flag_next   = cur_direct;
        unknown_flag_next  = cur_unknown;
        ob                 = data_byte;
        repl               = 1'b0;
        bstart             = 1'b0;

        case (cur_phase)
            PH_SIG:
            begin
                if (sig_inc >= SIG_END)
                begin
                    sig_count_next = '0;
                    phase_next     = PH_ID;
                end
                else
                begin
                    sig_count_next = sig_inc;
                end
            end
            PH_ID:
            begin
                bstart             = 1'b1;
                current_id_next    = data_byte;
                header_offset_next = '0;
                length_acc_next    = '0;
                if (!rule.known)
                begin
                    unknown_flag_next = 1'b1;
                end
                if ((data_byte == ID_STD || data_byte == ID_DIRECT ||
                     data_byte == ID_PAUSE) && cur_cnt != CNT_MAX)
                begin
                    block_counter_next = cur_cnt + 1'b1;
                end
                if (data_byte == ID_DIRECT)
                begin
                    direct_flag_next = 1'b1;
                end
                if (rule.hdr == 5'd0)
                begin
                    payload_left_next = pay_load;
                    phase_next        = (pay_load != 32'd0) ? PH_PAY : PH_ID;
                end
                else
                begin
                    phase_next = PH_HDR;
                end
            end
            PH_HDR:
            begin
                // Pause field, low byte first
                if (rule.has_pause)
                begin
                    if (cur_hoff == rule.pause_off)
                    begin
                        ob   = pause_ms[7:0];
                        repl = 1'b1;
                    end
                    else if ({1'b0, cur_hoff} == ({1'b0, rule.pause_off} + 6'd1))
                    begin
                        ob   = pause_ms[15:8];
                        repl = 1'b1;
                    end
                end
                length_acc_next    = acc_hdr;
                header_offset_next = hoff_inc;
                if (hoff_inc >= rule.hdr)
                begin
                    payload_left_next = pay_load;
                    phase_next        = (pay_load != 32'd0) ? PH_PAY : PH_ID;
                end
            end
            PH_PAY:
            begin
                payload_left_next = pay_dec;
                if (pay_dec == 32'd0)
                begin
                    phase_next = PH_ID;
                end
            end
            default:
            begin
                phase_next = PH_SIG;
            end
        endcase
    end

    // Reported count is limited to 16 bits
    assign cnt_ext = {16'd0, block_counter_next};

    always_comb
    begin
        res.out_byte          = ob;
        res.pause_replaced    = repl;
        res.block_start       = bstart;
        res.sound_block_count = (cnt_ext > (COUNT_BITS + 16)'(16'hFFFF)) ? 16'hFFFF
                                                                        : cnt_ext[15:0];
        res.saw_direct        = direct_flag_next;
        res.saw_unknown       = unknown_flag_next;
    end

    // Checks
    a_pay_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_PAY |-> payload_left_reg != 32'd0)
        else $error("payload phase with zero count");

    a_sig_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_SIG |-> sig_count_reg < SIG_END)
        else $error("signature count out of range");

    a_hdr_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_HDR |-> header_offset_reg < block_rule(current_id_reg).hdr)
        else $error("header offset past header size");

    a_id_no_pause: assert property (@(posedge clk) disable iff (!rst_n)
        !(res.block_start && res.pause_replaced))
        else $error("block ID byte marked as pause byte");

endmodule

// File: hdl/tape_block_pause_rewriter.sv
// Top level of the tape block pause rewriter: APB register, input/output
// handshake and result register around the block parser.
// Depends on tbpr_pkg and tbpr_parser.

// Takes a tape image one byte per transfer and returns one byte per transfer:
// the signature passes through, block pause fields of IDs 0x10, 0x11, 0x14,
// 0x15 and 0x20 are overwritten with pause_ms (APB register at address 0),
// and every result carries block-start, sound block count and sticky flags.
// Throughput is one byte per clock while out_ready keeps the result register
// drained; each result is held in the single result register fed by the parser
// logic. in_ready stays high while the result register is empty or being drained.
// The user must write pause_ms only while the block is idle; the block does not enforce it.
module tape_block_pause_rewriter
    import tbpr_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    // Output channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        pause_replaced,
    output logic        block_start,
    output logic [15:0] sound_block_count,
    output logic        saw_direct,
    output logic        saw_unknown
);

    logic [15:0] pause_ms_reg;
    logic        out_valid_reg, out_valid_next;
    result_t     res_reg;
    result_t     res;
    logic        step;
    logic        cfg_wr;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_PAUSE_MS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pause_ms_reg <= '0;
        end
        else if (cfg_wr)
        begin
            pause_ms_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr[2] == REG_PAUSE_MS) ? {16'd0, pause_ms_reg} : 32'd0;

    // Handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign step     = in_valid && in_ready;

    tbpr_parser #(
        .COUNT_BITS (COUNT_BITS)
    ) u_parser (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .pause_ms      (pause_ms_reg),
        .res           (res)
    );

    // Result register
    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            res_reg <= res;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_byte          = res_reg.out_byte;
    assign pause_replaced    = res_reg.pause_replaced;
    assign block_start       = res_reg.block_start;
    assign sound_block_count = res_reg.sound_block_count;
    assign saw_direct        = res_reg.saw_direct;
    assign saw_unknown       = res_reg.saw_unknown;

endmodule

// File: dv/tbpr_checker.sv
`timescale 1ns / 1ps
// Checker for the tape block pause rewriter: watches the APB port and both
// byte channels, predicts every result and compares it. Depends on tbpr_pkg.
module tbpr_checker
    import tbpr_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [7:0]  out_byte,
    input  logic        pause_replaced,
    input  logic        block_start,
    input  logic [15:0] sound_block_count,
    input  logic        saw_direct,
    input  logic        saw_unknown,
    output int          pending,
    output int          fail_count
);

    // Header layout of one block type
    typedef struct packed {
        logic [4:0] hdr;
        logic       has_pause;
        logic [4:0] pause_off;
        logic [4:0] len_off;
        logic [2:0] len_w;
        logic [1:0] mult;
        logic       known;
    } fmt_t;

    // Parser copy
    logic [15:0]           pause_val;
    phase_t                ph;
    logic [3:0]            sig_cnt;
    logic [7:0]            cur_id;
    logic [4:0]            hdr_off;
    logic [31:0]           len_acc;
    logic [31:0]           pay_left;
    logic [COUNT_BITS-1:0] sound_cnt;
    logic                  direct_seen;
    logic                  unknown_seen;

    result_t expected_q[$];
    int      bad;

    function automatic fmt_t id_format(input logic [7:0] id);
        fmt_t f;
        case (id)
            ID_STD:         f = '{5'd4,  1'b1, 5'd0,  5'd2,  3'd2, MULT_X1, 1'b1};
            ID_TURBO:       f = '{5'd18, 1'b1, 5'd13, 5'd15, 3'd3, MULT_X1, 1'b1};
            ID_TONE:        f = '{5'd4,  1'b0, 5'd0,  5'd0,  3'd0, MULT_X1, 1'b1};
            ID_PULSES:      f = '{5'd1,  1'b0, 5'd0,  5'd0,  3'd1, MULT_X2, 1'b1};
            ID_PURE_DATA:   f = '{5'd10, 1'b1, 5'd5,  5'd7,  3'd3, MULT_X1, 1'b1};
            ID_DIRECT:      f = '{5'd8,  1'b1, 5'd2,  5'd5,  3'd3, MULT_X1, 1'b1};
            ID_PAUSE:       f = '{5'd2,  1'b1, 5'd0,  5'd0,  3'd0, MULT_X1, 1'b1};
            ID_GROUP_START: f = '{5'd1,  1'b0, 5'd0,  5'd0,  3'd1, MULT_X1, 1'b1};
            ID_GROUP_END:   f = '{5'd0,  1'b0, 5'd0,  5'd0,  3'd0, MULT_X1, 1'b1};
            ID_JUMP:        f = '{5'd2,  1'b0, 5'd0,  5'd0,  3'd0, MULT_X1, 1'b1};
            ID_TEXT:        f = '{5'd1,  1'b0, 5'd0,  5'd0,  3'd1, MULT_X1, 1'b1};
            ID_MESSAGE:     f = '{5'd2,  1'b0, 5'd0,  5'd1,  3'd1, MULT_X1, 1'b1};
            ID_ARCHIVE:     f = '{5'd2,  1'b0, 5'd0,  5'd0,  3'd2, MULT_X1, 1'b1};
            ID_HW_TYPE:     f = '{5'd1,  1'b0, 5'd0,  5'd0,  3'd1, MULT_X3, 1'b1};
            ID_EMU_INFO:    f = '{5'd8,  1'b0, 5'd0,  5'd0,  3'd0, MULT_X1, 1'b1};
            ID_CUSTOM:      f = '{5'd20, 1'b0, 5'd0,  5'd16, 3'd4, MULT_X1, 1'b1};
            ID_SNAPSHOT:    f = '{5'd11, 1'b0, 5'd0,  5'd8,  3'd3, MULT_X1, 1'b1};
            ID_GLUE:        f = '{5'd9,  1'b0, 5'd0,  5'd0,  3'd0, MULT_X1, 1'b1};
            // extension rule: 4-byte length right at the start of the header
            default:        f = '{5'd4,  1'b0, 5'd0,  5'd0,  3'd4, MULT_X1, 1'b0};
        endcase
        return f;
    endfunction

    function automatic void clear_parse();
        ph           = PH_SIG;
        sig_cnt      = '0;
        cur_id       = '0;
        hdr_off      = '0;
        len_acc      = '0;
        pay_left     = '0;
        sound_cnt    = '0;
        direct_seen  = 1'b0;
        unknown_seen = 1'b0;
    endfunction

    // Header complete: load payload count, or expect the next ID right away
    function automatic void finish_header(input fmt_t f);
        pay_left = len_acc * 32'(f.mult);
        ph = (pay_left != 0) ? PH_PAY : PH_ID;
    endfunction

    // Advance the parser by one byte and return the result it produces
    function automatic result_t predict_byte(input logic [7:0] b, input logic sof);
        result_t     res;
        fmt_t        f;
        logic [4:0]  d;
        logic [31:0] wide;
        res.out_byte       = b;
        res.pause_replaced = 1'b0;
        res.block_start    = 1'b0;
        if (sof)
            clear_parse();
        case (ph)
            PH_SIG:
            begin
                sig_cnt = sig_cnt + 4'd1;
                if (sig_cnt >= SIG_LEN)
                begin
                    sig_cnt = '0;
                    ph = PH_ID;
                end
            end
            PH_ID:
            begin
                res.block_start = 1'b1;
                cur_id  = b;
                hdr_off = '0;
                len_acc = '0;
                f = id_format(b);
                if (!f.known)
                    unknown_seen = 1'b1;
                if ((b == ID_STD || b == ID_DIRECT || b == ID_PAUSE) &&
                    sound_cnt != {COUNT_BITS{1'b1}})
                    sound_cnt = sound_cnt + 1'b1;
                if (b == ID_DIRECT)
                    direct_seen = 1'b1;
                if (f.hdr == 0)
                    finish_header(f);
                else
                    ph = PH_HDR;
            end
            PH_HDR:
            begin
                f = id_format(cur_id);
                // pause field, low byte first
                if (f.has_pause)
                begin
                    if (hdr_off == f.pause_off)
                    begin
                        res.out_byte       = pause_val[7:0];
                        res.pause_replaced = 1'b1;
                    end
                    else if (6'(hdr_off) == 6'(f.pause_off) + 6'd1)
                    begin
                        res.out_byte       = pause_val[15:8];
                        res.pause_replaced = 1'b1;
                    end
                end
                // little-endian length field
                if (f.len_w != 0 && hdr_off >= f.len_off &&
                    6'(hdr_off) < 6'(f.len_off) + 6'(f.len_w))
                begin
                    d = hdr_off - f.len_off;
                    len_acc = len_acc | (32'(b) << {d[1:0], 3'b000});
                end
                hdr_off = hdr_off + 5'd1;
                if (hdr_off >= f.hdr)
                    finish_header(f);
            end
            default:
            begin
                pay_left = pay_left - 32'd1;
                if (pay_left == 0)
                    ph = PH_ID;
            end
        endcase
        wide = 32'(sound_cnt);
        res.sound_block_count = (wide > 32'hFFFF) ? 16'hFFFF : wide[15:0];
        res.saw_direct  = direct_seen;
        res.saw_unknown = unknown_seen;
        return res;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h actual %0h", $time, name, want, got);
            bad = bad + 1;
        end
    endfunction

    // Sample on each edge: results first, then new transfers, then APB writes
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            clear_parse();
            pause_val = '0;
            expected_q.delete();
            bad = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result: expected none actual byte %0h",
                             $time, out_byte);
                    bad = bad + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("out_byte", 16'(want.out_byte), 16'(out_byte));
                    check_field("pause_replaced", 16'(want.pause_replaced),
                                16'(pause_replaced));
                    check_field("block_start", 16'(want.block_start), 16'(block_start));
                    check_field("sound_block_count", want.sound_block_count,
                                sound_block_count);
                    check_field("saw_direct", 16'(want.saw_direct), 16'(saw_direct));
                    check_field("saw_unknown", 16'(want.saw_unknown), 16'(saw_unknown));
                end
            end
            if (in_valid && in_ready)
                expected_q.push_back(predict_byte(data_byte, start_of_file));
            if (psel && penable && pwrite && pready && (paddr >> 2) == 3'(REG_PAUSE_MS))
                pause_val = pwdata[15:0];
        end
        pending    <= expected_q.size();
        fail_count <= bad;
    end

endmodule

// File: dv/testbench.sv
`timescale 1ns / 1ps
// Testbench top for the tape block pause rewriter: clock, reset, APB writes
// and tape image stimulus. Depends on tbpr_pkg, tape_block_pause_rewriter, tbpr_checker.
module testbench;
    import tbpr_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 4_000_000;
    localparam logic [2:0]  PAUSE_ADDR  = {REG_PAUSE_MS, 2'b00};
    localparam logic [2:0]  SPARE_ADDR  = {~REG_PAUSE_MS, 2'b00};
    localparam logic [7:0]  ID_UNLISTED = 8'hFF;

    // Block layout as far as the stimulus needs it
    typedef struct packed {
        logic [4:0] hdr;
        logic [4:0] loff;
        logic [2:0] lw;
        logic [1:0] mult;
        logic       known;
    } shape_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        start_of_file;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  out_byte;
    logic        pause_replaced;
    logic        block_start;
    logic [15:0] sound_block_count;
    logic        saw_direct;
    logic        saw_unknown;

    int          fail_count;
    int          pending;
    int unsigned cycles = 0;
    int          items = 0;
    int          item_goal;
    logic        src_idle = 1'b1;
    logic        sink_idle = 1'b1;
    logic [7:0]  seq [$];

    tape_block_pause_rewriter uut (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .data_byte         (data_byte),
        .start_of_file     (start_of_file),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .pause_replaced    (pause_replaced),
        .block_start       (block_start),
        .sound_block_count (sound_block_count),
        .saw_direct        (saw_direct),
        .saw_unknown       (saw_unknown)
    );

    tbpr_checker chk (
        .clk               (clk),
        .rst_n             (rst_n),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .pready            (pready),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .data_byte         (data_byte),
        .start_of_file     (start_of_file),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .pause_replaced    (pause_replaced),
        .block_start       (block_start),
        .sound_block_count (sound_block_count),
        .saw_direct        (saw_direct),
        .saw_unknown       (saw_unknown),
        .pending           (pending),
        .fail_count        (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
        cycles <= cycles + 1;

    // Watchdog
    initial
    begin
        wait (cycles >= CYCLE_LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    // Gap length: mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 2);
        if (r < 95)
            return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    // Receiver back-pressure
    initial
    begin : sink
        int hold;
        hold = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold = hold - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (sink_idle && $urandom_range(0, 4) == 0)
                    hold = gap_len();
            end
        end
    end

    function automatic shape_t block_shape(input logic [7:0] id);
        shape_t s;
        case (id)
            ID_STD:         s = '{5'd4,  5'd2,  3'd2, MULT_X1, 1'b1};
            ID_TURBO:       s = '{5'd18, 5'd15, 3'd3, MULT_X1, 1'b1};
            ID_TONE:        s = '{5'd4,  5'd0,  3'd0, MULT_X1, 1'b1};
            ID_PULSES:      s = '{5'd1,  5'd0,  3'd1, MULT_X2, 1'b1};
            ID_PURE_DATA:   s = '{5'd10, 5'd7,  3'd3, MULT_X1, 1'b1};
            ID_DIRECT:      s = '{5'd8,  5'd5,  3'd3, MULT_X1, 1'b1};
            ID_PAUSE:       s = '{5'd2,  5'd0,  3'd0, MULT_X1, 1'b1};
            ID_GROUP_START: s = '{5'd1,  5'd0,  3'd1, MULT_X1, 1'b1};
            ID_GROUP_END:   s = '{5'd0,  5'd0,  3'd0, MULT_X1, 1'b1};
            ID_JUMP:        s = '{5'd2,  5'd0,  3'd0, MULT_X1, 1'b1};
            ID_TEXT:        s = '{5'd1,  5'd0,  3'd1, MULT_X1, 1'b1};
            ID_MESSAGE:     s = '{5'd2,  5'd1,  3'd1, MULT_X1, 1'b1};
            ID_ARCHIVE:     s = '{5'd2,  5'd0,  3'd2, MULT_X1, 1'b1};
            ID_HW_TYPE:     s = '{5'd1,  5'd0,  3'd1, MULT_X3, 1'b1};
            ID_EMU_INFO:    s = '{5'd8,  5'd0,  3'd0, MULT_X1, 1'b1};
            ID_CUSTOM:      s = '{5'd20, 5'd16, 3'd4, MULT_X1, 1'b1};
            ID_SNAPSHOT:    s = '{5'd11, 5'd8,  3'd3, MULT_X1, 1'b1};
            ID_GLUE:        s = '{5'd9,  5'd0,  3'd0, MULT_X1, 1'b1};
            default:        s = '{5'd4,  5'd0,  3'd4, MULT_X1, 1'b0};
        endcase
        return s;
    endfunction

    // Length field value: mostly small, some zero, a few at 255 or just past a byte
    function automatic logic [31:0] pick_len(input logic [2:0] lw);
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 32'd0;
        if (r < 85)
            return $urandom_range(1, 6);
        if (r < 97)
            return $urandom_range(7, 40);
        return (lw == 3'd1) ? 32'd255 : $urandom_range(256, 300);
    endfunction

    // One byte transfer, then an optional gap
    task automatic put_byte(input logic [7:0] b, input logic sof);
        in_valid      <= 1'b1;
        data_byte     <= b;
        start_of_file <= sof;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        items = items + 1;
        if (src_idle && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
    endtask

    // APB write: setup cycle, access cycle, then back to idle
    task automatic reg_write(input logic [2:0] addr, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    // Stop sending and wait for every outstanding result
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    // One block; noisy blocks carry a random length and are cut in the payload
    task automatic send_block(input logic [7:0] id, input logic noisy, output logic ended);
        shape_t      s;
        logic [31:0] len;
        logic [7:0]  b;
        int          total;
        int          nbytes;
        int          off;
        int          i;
        s = block_shape(id);
        ended = noisy;
        len = noisy ? $urandom : pick_len(s.lw);
        if (s.lw == 0)
            len = '0;
        total = 1 + int'(s.hdr) +
                (noisy ? int'($urandom_range(0, 8)) : int'(len) * int'(s.mult));
        nbytes = total;
        // truncated image: next image restarts the parser
        if (!noisy && $urandom_range(0, 11) == 0)
        begin
            nbytes = $urandom_range(1, total);
            ended = 1'b1;
        end
        for (i = 0; i < nbytes; i++)
        begin
            off = i - 1;
            if (i == 0)
                b = id;
            else if (i <= int'(s.hdr) && s.lw != 0 && off >= int'(s.loff) &&
                     off < int'(s.loff) + int'(s.lw))
                b = len[8 * (off - int'(s.loff)) +: 8];
            else
                b = 8'($urandom_range(0, 255));
            put_byte(b, 1'b0);
        end
    endtask

    // Signature and a run of blocks, mostly well formed
    task automatic send_image();
        shape_t     sh;
        logic [7:0] id;
        logic       ended;
        logic       want_known;
        int         sig_cut;
        int         nblk;
        int         k;
        int         r;
        sig_cut = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 9) : SIG_LEN;
        for (k = 0; k < sig_cut; k++)
            put_byte(8'($urandom_range(0, 255)), k == 0);
        if (sig_cut < SIG_LEN)
            return;
        nblk = $urandom_range(1, 12);
        ended = 1'b0;
        for (k = 0; k < nblk && !ended && items < item_goal; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 92)
            begin
                want_known = (r < 80);
                do
                begin
                    id = 8'($urandom_range(0, 255));
                    sh = block_shape(id);
                end
                while (sh.known != want_known);
                send_block(id, 1'b0, ended);
            end
            else
                send_block(8'($urandom_range(0, 255)), 1'b1, ended);
        end
    endtask

    task automatic run_chunk(input int goal, input logic idle_on);
        item_goal = goal;
        src_idle  = idle_on;
        sink_idle = idle_on;
        while (items < goal)
            send_image();
        drain();
    endtask

    initial
    begin : stim
        int   i;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        in_valid      <= 1'b0;
        data_byte     <= '0;
        start_of_file <= 1'b0;
        item_goal     = 1 << 30;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: image straight after reset with the reset pause value,
        // pause block, zero-size header, direct recording with zero payload,
        // unknown ID with a one-byte payload, then a restart on an ID byte
        seq = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h55, 8'hAA,
                ID_PAUSE, 8'hFF, 8'h00,
                ID_GROUP_END,
                ID_DIRECT, 8'h11, 8'h22, 8'h33, 8'h44, 8'h55, 8'h00, 8'h00, 8'h00,
                ID_UNLISTED, 8'h01, 8'h00, 8'h00, 8'h00, 8'hC3,
                8'h00};
        for (i = 0; i < seq.size(); i++)
            put_byte(seq[i], i == seq.size() - 1);
        drain();

        // No register at the second address; upper data bits are dropped
        reg_write(SPARE_ADDR, 32'hFFFF_FFFF);
        reg_write(PAUSE_ADDR, 32'hFFFF_FFFF);
        run_chunk(230, 1'b1);
        reg_write(PAUSE_ADDR, {16'($urandom), 16'h0000});
        run_chunk(430, 1'b1);
        reg_write(PAUSE_ADDR, $urandom);
        run_chunk(630, 1'b0);
        reg_write(PAUSE_ADDR, $urandom);
        run_chunk(850, 1'b1);
        repeat (5) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
